FILE: rtl/core/stt_pkg.sv
// ----------------------------------------------------------------------------
// Source text tokenizer package
// Transaction types, token kind codes and scanner mode codes.
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_source;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  lexeme_char;
        logic        token_first;
        logic        token_last;
        logic [23:0] line_number;
        logic [62:0] int_value;
        logic        unterminated;
    } t_out_item;

    localparam logic [2:0] KIND_INT     = 3'd0;
    localparam logic [2:0] KIND_FLOAT   = 3'd1;
    localparam logic [2:0] KIND_IDENT   = 3'd2;
    localparam logic [2:0] KIND_STRING  = 3'd3;
    localparam logic [2:0] KIND_OP      = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;
    localparam logic [2:0] KIND_UNKNOWN = 3'd6;

    localparam logic [23:0] LINE_MAX  = 24'hFFFFFF;
    localparam logic [62:0] VALUE_MAX = {63{1'b1}};
    localparam logic [8:0]  SYM_END   = 9'h100;

    typedef enum logic [12:0] {
        M_IDLE     = 13'b0000000000001,
        M_SLASH    = 13'b0000000000010,
        M_OP2      = 13'b0000000000100,
        M_QOPEN    = 13'b0000000001000,
        M_STRING   = 13'b0000000010000,
        M_LINECMT  = 13'b0000000100000,
        M_BLOCKCMT = 13'b0000001000000,
        M_INT      = 13'b0000010000000,
        M_FRAC     = 13'b0000100000000,
        M_EXP_E    = 13'b0001000000000,
        M_EXP_SIGN = 13'b0010000000000,
        M_EXPDIG   = 13'b0100000000000,
        M_IDENT    = 13'b1000000000000
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_seq;

endpackage

FILE: rtl/core/source_text_tokenizer.sv
// ----------------------------------------------------------------------------
// Source text tokenizer
// Scans source bytes and emits one transaction per lexeme character, or one for a token that has none.
// ----------------------------------------------------------------------------
// Each accepted byte is scanned by a small sequencer that runs one scanner
// step per cycle. A byte is first registered into the symbol queue and its
// steps follow; a zero byte is dropped on acceptance and takes no step.
// A byte needs one step, plus one each time it must be seen
// again (the byte that ends a token, a pending slash, operator or opening
// quote, and end of input leaving a comment), plus the steps of up to two
// held exponent bytes replayed after a float ends, plus one extra step for
// each two-character operator and up to two for a completed exponent. The
// input is stalled while steps remain; a step also waits while the output
// register holds a stalled transaction. Integer digits after the first go
// through one shift-and-add unit that forms value*10+digit with saturation.
module source_text_tokenizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  stt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output stt_pkg::t_out_item o_out_data
);

    stt_pkg::t_seq  r_seq, n_seq;
    stt_pkg::t_mode r_mode, n_mode;
    logic [8:0]  r_q [3];
    logic [8:0]  n_q [3];
    logic [1:0]  r_cnt, n_cnt;
    logic [1:0]  r_sub, n_sub;
    logic [7:0]  r_held [2];
    logic [7:0]  n_held [2];
    logic [1:0]  r_hcnt, n_hcnt;
    logic [62:0] r_acc, n_acc;
    logic [23:0] r_line, n_line;
    logic [23:0] r_tline, n_tline;
    logic        r_qk, n_qk;
    logic [1:0]  r_qrun, n_qrun;
    logic        r_esc, n_esc;
    logic        r_pv, n_pv;
    logic        r_pf, n_pf;
    logic [7:0]  r_pc, n_pc;
    logic [2:0]  r_pk, n_pk;
    logic        r_ov, n_ov;
    stt_pkg::t_out_item r_od, n_od;

    logic        out_free, go, accept;
    logic [8:0]  sym;
    logic [7:0]  b;
    logic        isend, dig, alpha, space, idch, delim_hit;
    logic        e;
    stt_pkg::t_out_item ed;
    logic        do_push, do_fin, consume, requeue, do_clear, bump;
    logic [7:0]  push_ch, dec;
    logic [2:0]  push_k, fin_k;
    logic [62:0] fin_v;
    logic        fin_u;
    logic [66:0] prod;

    function automatic logic op_one(input logic [7:0] c);
        return c == "(" || c == ")" || c == "{" || c == "}" || c == ";" ||
               c == "," || c == "+" || c == "-" || c == "*" || c == "%";
    endfunction

    function automatic logic op_two(input logic [7:0] c);
        return c == "=" || c == "<" || c == ">" || c == "!" || c == "&" || c == "|";
    endfunction

    function automatic logic pairs(input logic [7:0] f, input logic [7:0] c);
        if (c == "=") begin
            return f == "=" || f == "!" || f == "<" || f == ">";
        end
        return (f == "&" && c == "&") || (f == "|" && c == "|");
    endfunction

    assign out_free    = !r_ov || !i_out_stall;
    assign go          = (r_seq == stt_pkg::S_RUN) && out_free;
    assign o_in_stall  = r_seq != stt_pkg::S_IDLE;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

    assign sym   = r_q[0];
    assign b     = sym[7:0];
    assign isend = sym[8];
    assign dig   = !isend && b >= "0" && b <= "9";
    assign alpha = !isend && ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z"));
    assign space = !isend && (b == " " || (b >= 8'd9 && b <= 8'd13));
    assign idch  = alpha || dig || (!isend && b == "_");
    assign delim_hit = !isend && (b == (r_qk ? 8'h27 : 8'h22));
    assign prod  = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {59'd0, b - "0"};

    always_comb begin
        unique case (b)
            "n":     dec = 8'h0A;
            "t":     dec = 8'h09;
            "r":     dec = 8'h0D;
            default: dec = b;
        endcase
    end

    always_comb begin
        n_mode = r_mode;   n_sub = r_sub;   n_held = r_held; n_hcnt = r_hcnt;
        n_acc = r_acc;     n_line = r_line; n_tline = r_tline;
        n_qk = r_qk;       n_qrun = r_qrun; n_esc = r_esc;
        n_pv = r_pv;       n_pf = r_pf;     n_pc = r_pc;     n_pk = r_pk;
        e = 1'b0;
        ed = '0;
        ed.line_number = (r_mode == stt_pkg::M_IDLE) ? r_line : r_tline;
        do_push = 1'b0; push_ch = b; push_k = stt_pkg::KIND_INT;
        do_fin = 1'b0;  fin_k = stt_pkg::KIND_INT; fin_v = '0; fin_u = 1'b0;
        consume = 1'b1; requeue = 1'b0; do_clear = 1'b0; bump = 1'b0;

        unique case (r_mode)
            stt_pkg::M_IDLE: begin
                if (isend) begin
                    e = 1'b1;
                    ed.token_kind = stt_pkg::KIND_END;
                    ed.token_first = 1'b1;
                    ed.token_last = 1'b1;
                    do_clear = 1'b1;
                end else if (b == 8'h0A) begin
                    bump = 1'b1;
                end else if (!space) begin
                    n_tline = r_line;
                    n_pv = 1'b0;
                    if (b == "/") begin
                        n_mode = stt_pkg::M_SLASH;
                    end else if (b == 8'h22) begin
                        n_qk = 1'b0; n_qrun = 2'd1; n_mode = stt_pkg::M_QOPEN;
                    end else if (b == 8'h27) begin
                        n_qk = 1'b1; n_esc = 1'b0; n_mode = stt_pkg::M_STRING;
                    end else if (dig) begin
                        n_acc = {55'd0, b - "0"};
                        do_push = 1'b1; push_k = stt_pkg::KIND_INT;
                        n_mode = stt_pkg::M_INT;
                    end else if (idch) begin
                        do_push = 1'b1; push_k = stt_pkg::KIND_IDENT;
                        n_mode = stt_pkg::M_IDENT;
                    end else if (op_one(b)) begin
                        e = 1'b1; ed.token_kind = stt_pkg::KIND_OP; ed.lexeme_char = b;
                        ed.token_first = 1'b1; ed.token_last = 1'b1;
                    end else if (op_two(b)) begin
                        n_pc = b; n_mode = stt_pkg::M_OP2;
                    end else begin
                        e = 1'b1; ed.token_kind = stt_pkg::KIND_UNKNOWN; ed.lexeme_char = b;
                        ed.token_first = 1'b1; ed.token_last = 1'b1;
                    end
                end
            end
            stt_pkg::M_SLASH: begin
                if (!isend && b == "/") begin
                    n_mode = stt_pkg::M_LINECMT;
                end else begin
                    e = 1'b1; ed.token_kind = stt_pkg::KIND_OP; ed.lexeme_char = "/";
                    ed.token_first = 1'b1; ed.token_last = 1'b1;
                    n_mode = stt_pkg::M_IDLE; consume = 1'b0;
                end
            end
            stt_pkg::M_OP2: begin
                e = 1'b1; ed.token_kind = stt_pkg::KIND_OP;
                if (r_sub == 2'd1) begin
                    ed.lexeme_char = b; ed.token_last = 1'b1;
                    n_sub = 2'd0; n_mode = stt_pkg::M_IDLE;
                end else if (!isend && pairs(r_pc, b)) begin
                    ed.lexeme_char = r_pc; ed.token_first = 1'b1;
                    n_sub = 2'd1; consume = 1'b0;
                end else begin
                    ed.lexeme_char = r_pc; ed.token_first = 1'b1; ed.token_last = 1'b1;
                    n_mode = stt_pkg::M_IDLE; consume = 1'b0;
                end
            end
            stt_pkg::M_QOPEN: begin
                n_qrun = 2'd0;
                if (r_qrun == 2'd1) begin
                    if (!isend && b == 8'h22) begin
                        n_qrun = 2'd2;
                    end else begin
                        n_esc = 1'b0; n_mode = stt_pkg::M_STRING; consume = 1'b0;
                    end
                end else if (!isend && b == 8'h22) begin
                    n_mode = stt_pkg::M_BLOCKCMT;
                end else begin
                    do_fin = 1'b1; fin_k = stt_pkg::KIND_STRING; consume = 1'b0;
                end
            end
            stt_pkg::M_STRING: begin
                if (isend) begin
                    n_esc = 1'b0; do_fin = 1'b1; fin_k = stt_pkg::KIND_STRING;
                    fin_u = 1'b1; consume = 1'b0;
                end else if (r_esc) begin
                    n_esc = 1'b0; do_push = 1'b1; push_ch = dec;
                    push_k = stt_pkg::KIND_STRING;
                end else if (delim_hit) begin
                    do_fin = 1'b1; fin_k = stt_pkg::KIND_STRING;
                end else if (b == 8'h5C) begin
                    n_esc = 1'b1;
                end else begin
                    do_push = 1'b1; push_k = stt_pkg::KIND_STRING;
                end
            end
            stt_pkg::M_LINECMT: begin
                if (isend) begin
                    n_mode = stt_pkg::M_IDLE; consume = 1'b0;
                end else if (b == 8'h0A) begin
                    bump = 1'b1; n_mode = stt_pkg::M_IDLE;
                end
            end
            stt_pkg::M_BLOCKCMT: begin
                if (isend) begin
                    n_qrun = 2'd0; n_mode = stt_pkg::M_IDLE; consume = 1'b0;
                end else begin
                    bump = b == 8'h0A;
                    if (b == 8'h22) begin
                        if (r_qrun == 2'd2) begin
                            n_qrun = 2'd0; n_mode = stt_pkg::M_IDLE;
                        end else begin
                            n_qrun = r_qrun + 2'd1;
                        end
                    end else begin
                        n_qrun = 2'd0;
                    end
                end
            end
            stt_pkg::M_INT: begin
                if (dig) begin
                    n_acc = (prod > {4'd0, stt_pkg::VALUE_MAX}) ? stt_pkg::VALUE_MAX
                                                                : prod[62:0];
                    do_push = 1'b1; push_k = stt_pkg::KIND_INT;
                end else if (!isend && b == ".") begin
                    do_push = 1'b1; push_k = stt_pkg::KIND_FLOAT;
                    n_mode = stt_pkg::M_FRAC;
                end else begin
                    do_fin = 1'b1; fin_k = stt_pkg::KIND_INT; fin_v = r_acc; consume = 1'b0;
                end
            end
            stt_pkg::M_FRAC: begin
                if (dig) begin
                    do_push = 1'b1; push_k = stt_pkg::KIND_FLOAT;
                end else if (!isend && (b == "e" || b == "E")) begin
                    n_held[0] = b; n_hcnt = 2'd1; n_mode = stt_pkg::M_EXP_E;
                end else begin
                    do_fin = 1'b1; fin_k = stt_pkg::KIND_FLOAT; consume = 1'b0;
                end
            end
            stt_pkg::M_EXP_E, stt_pkg::M_EXP_SIGN: begin
                if (dig) begin
                    do_push = 1'b1; push_k = stt_pkg::KIND_FLOAT;
                    if (r_sub == 2'd0) begin
                        push_ch = r_held[0]; n_sub = 2'd1; consume = 1'b0;
                    end else if (r_sub == 2'd1 && r_mode == stt_pkg::M_EXP_SIGN) begin
                        push_ch = r_held[1]; n_sub = 2'd2; consume = 1'b0;
                    end else begin
                        n_sub = 2'd0; n_hcnt = 2'd0; n_mode = stt_pkg::M_EXPDIG;
                    end
                end else if (r_mode == stt_pkg::M_EXP_E && !isend && (b == "+" || b == "-")) begin
                    n_held[1] = b; n_hcnt = 2'd2; n_mode = stt_pkg::M_EXP_SIGN;
                end else begin
                    do_fin = 1'b1; fin_k = stt_pkg::KIND_FLOAT;
                    consume = 1'b0; requeue = 1'b1; n_hcnt = 2'd0;
                end
            end
            stt_pkg::M_EXPDIG: begin
                if (dig) begin
                    do_push = 1'b1; push_k = stt_pkg::KIND_FLOAT;
                end else begin
                    do_fin = 1'b1; fin_k = stt_pkg::KIND_FLOAT; consume = 1'b0;
                end
            end
            stt_pkg::M_IDENT: begin
                if (idch) begin
                    do_push = 1'b1; push_k = stt_pkg::KIND_IDENT;
                end else begin
                    do_fin = 1'b1; fin_k = stt_pkg::KIND_IDENT; consume = 1'b0;
                end
            end
            default: begin
                n_mode = stt_pkg::M_IDLE; consume = 1'b0;
            end
        endcase

        if (do_push) begin
            if (r_pv) begin
                e = 1'b1; ed.token_kind = r_pk; ed.lexeme_char = r_pc;
                ed.token_first = r_pf; ed.token_last = 1'b0;
            end
            n_pc = push_ch; n_pk = push_k; n_pf = !r_pv; n_pv = 1'b1;
        end
        if (do_fin) begin
            e = 1'b1;
            ed.token_last = 1'b1; ed.int_value = fin_v; ed.unterminated = fin_u;
            if (r_pv) begin
                ed.token_kind = r_pk; ed.lexeme_char = r_pc; ed.token_first = r_pf;
            end else begin
                ed.token_kind = fin_k; ed.lexeme_char = 8'd0; ed.token_first = 1'b1;
            end
            n_pv = 1'b0; n_mode = stt_pkg::M_IDLE;
        end
        if (bump && r_line != stt_pkg::LINE_MAX) begin
            n_line = r_line + 24'd1;
        end
        if (do_clear) begin
            n_mode = stt_pkg::M_IDLE; n_sub = 2'd0; n_hcnt = 2'd0; n_acc = '0;
            n_line = 24'd1; n_tline = 24'd1; n_qk = 1'b0; n_qrun = 2'd0;
            n_esc = 1'b0; n_pv = 1'b0; n_pf = 1'b0; n_pc = 8'd0; n_pk = stt_pkg::KIND_INT;
        end
    end

    always_comb begin
        n_seq = r_seq;
        n_q   = r_q;
        n_cnt = r_cnt;
        if (accept) begin
            if (i_in_data.end_of_source) begin
                n_q[0] = stt_pkg::SYM_END; n_cnt = 2'd1; n_seq = stt_pkg::S_RUN;
            end else if (i_in_data.source_byte != 8'd0) begin
                n_q[0] = {1'b0, i_in_data.source_byte}; n_cnt = 2'd1;
                n_seq = stt_pkg::S_RUN;
            end
        end else if (go) begin
            if (consume) begin
                n_q[0] = r_q[1];
                n_q[1] = r_q[2];
                n_cnt  = r_cnt - 2'd1;
                if (r_cnt == 2'd1) begin
                    n_seq = stt_pkg::S_IDLE;
                end
            end else if (requeue && r_hcnt != 2'd0) begin
                n_q[0] = {1'b0, r_held[0]};
                if (r_hcnt == 2'd1) begin
                    n_q[1] = r_q[0];
                    n_cnt  = r_cnt + 2'd1;
                end else begin
                    n_q[1] = {1'b0, r_held[1]};
                    n_q[2] = r_q[0];
                    n_cnt  = r_cnt + 2'd2;
                end
            end
        end
        n_ov = r_ov;
        n_od = r_od;
        if (go && e) begin
            n_ov = 1'b1; n_od = ed;
        end else if (!i_out_stall) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q    <= n_q;
        r_od   <= n_od;
        if (go) begin
            r_held <= n_held;
            r_pc   <= n_pc;
            r_pk   <= n_pk;
            r_pf   <= n_pf;
        end
        if (!i_rst_n) begin
            r_seq <= stt_pkg::S_IDLE;  r_cnt <= 2'd0;  r_ov <= 1'b0;
            r_mode <= stt_pkg::M_IDLE; r_sub <= 2'd0;  r_hcnt <= 2'd0;
            r_acc <= '0;  r_line <= 24'd1;  r_tline <= 24'd1;
            r_qk <= 1'b0; r_qrun <= 2'd0;   r_esc <= 1'b0; r_pv <= 1'b0;
        end else begin
            r_seq <= n_seq; r_cnt <= n_cnt; r_ov <= n_ov;
            if (go) begin
                r_mode <= n_mode; r_sub <= n_sub; r_hcnt <= n_hcnt;
                r_acc <= n_acc;   r_line <= n_line; r_tline <= n_tline;
                r_qk <= n_qk;     r_qrun <= n_qrun; r_esc <= n_esc; r_pv <= n_pv;
            end
        end
    end

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq == stt_pkg::S_IDLE |-> r_cnt == 2'd0)
        else $error("sequencer idle with symbols queued");

    a_sub_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sub != 2'd0 |-> (r_mode == stt_pkg::M_OP2 || r_mode == stt_pkg::M_EXP_E ||
                           r_mode == stt_pkg::M_EXP_SIGN))
        else $error("substep outside a multi-step mode");

    a_idle_nopend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == stt_pkg::M_IDLE |-> !r_pv)
        else $error("held lexeme character between tokens");

    a_end_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.token_kind == stt_pkg::KIND_END |->
        o_out_data.token_first && o_out_data.token_last)
        else $error("end token not a single transaction");

endmodule
